@@ hdl/rmth_pkg.sv @@
// ============================================================================
// rmth_pkg
// shared constants and types for the running median two-heap block
// ============================================================================
package rmth_pkg;
    localparam int unsigned CAPACITY_DEF     = 1024;
    localparam int unsigned SAMPLE_WIDTH_DEF = 32;
    localparam int unsigned SAMPLE_PORT_W    = 32;
    localparam int unsigned MEDIAN_PORT_W    = 33;
    localparam int unsigned COUNT_PORT_W     = 11;

    // heap operation codes
    typedef enum logic [1:0] {
        t_OP_PUSH = 2'd0,
        t_OP_POP  = 2'd1
    } t_heap_op;

    typedef struct packed {
        logic     start;
        t_heap_op op;
    } t_heap_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_heap_stat;
endpackage

@@ hdl/rmth_heap.sv @@
// ============================================================================
// rmth_heap
// one binary heap in a synchronous memory, push and pop by sift over cycles
// ============================================================================
module rmth_heap #(
    parameter int unsigned DEPTH  = rmth_pkg::CAPACITY_DEF / 2 + 1,
    parameter int unsigned W      = rmth_pkg::SAMPLE_WIDTH_DEF,
    parameter bit          IS_MAX = 1'b1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rmth_pkg::t_heap_cmd   i_cmd,
    input  logic [W-1:0]          i_value,
    output rmth_pkg::t_heap_stat  o_stat,
    output logic [W-1:0]          o_top,
    output logic [W-1:0]          o_pop_value,
    output logic [$clog2(DEPTH+1)-1:0] o_size
);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned SW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_L, S_DN_CMP
    } t_state;

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;
    logic [AW-1:0] n_rd_addr;
    logic          n_we;
    logic [AW-1:0] n_wr_addr;
    logic [W-1:0]  n_wr_data;

    t_state        r_state;
    logic [SW-1:0] r_size;
    logic [AW-1:0] r_idx;
    logic [W-1:0]  r_val;   // value being sifted
    logic [W-1:0]  r_top;   // cached copy of entry zero
    logic [W-1:0]  r_left;
    logic [W-1:0]  r_popv;
    logic          r_done;

    function automatic logic precedes(input logic [W-1:0] a, input logic [W-1:0] b);
        return IS_MAX ? (a > b) : (a < b);
    endfunction

    // child and parent addressing
    logic [SW:0] w_l, w_r;
    logic [AW-1:0] w_par;
    assign w_l   = (SW+1)'({r_idx, 1'b1});
    assign w_r   = w_l + 1'b1;
    assign w_par = AW'((r_idx - 1'b1) >> 1);

    // sift decisions: move up past the parent, or down to the left or right child
    logic w_up_swap, w_has_l, w_has_r, w_take_l, w_take_r, w_finish;
    assign w_up_swap = (r_idx != '0) && precedes(r_val, r_rd_data);
    assign w_has_l   = w_l < (SW+1)'(r_size);
    assign w_has_r   = w_r < (SW+1)'(r_size);
    assign w_take_l  = w_has_l && precedes(r_left, r_val) &&
                       !(w_has_r && precedes(r_rd_data, r_left));
    assign w_take_r  = !w_take_l && w_has_r && precedes(r_rd_data, r_val);
    assign w_finish  = ((r_state == S_UP_CMP) && !w_up_swap) ||
                       ((r_state == S_DN_CMP) && !w_take_l && !w_take_r);

    // memory port
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
        r_rd_data <= r_mem[n_rd_addr];
    end

    always_comb begin
        n_rd_addr = '0;
        n_we      = 1'b0;
        n_wr_addr = r_idx;
        n_wr_data = r_val;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start && i_cmd.op == rmth_pkg::t_OP_POP) begin
                    n_rd_addr = AW'(r_size - 1'b1);
                end
            end
            S_UP_RD:  n_rd_addr = w_par;
            S_UP_CMP: begin
                n_rd_addr = w_par;
                n_we      = 1'b1;
                if (w_up_swap) n_wr_data = r_rd_data;
            end
            S_DN_RD: n_rd_addr = AW'(w_l);
            S_DN_L:  n_rd_addr = AW'(w_r);
            S_DN_CMP: begin
                n_we = 1'b1;
                if (w_take_l) n_wr_data = r_left;
                else if (w_take_r) n_wr_data = r_rd_data;
            end
            default: ;
        endcase
    end

    // sift sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= '0;
            r_done  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_done <= w_finish;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.start && i_cmd.op == rmth_pkg::t_OP_PUSH) begin
                        r_val   <= i_value;
                        r_idx   <= AW'(r_size);
                        r_size  <= r_size + 1'b1;
                        r_state <= S_UP_RD;
                    end else if (i_cmd.start) begin
                        r_popv  <= r_top;
                        r_size  <= r_size - 1'b1;
                        r_idx   <= '0;
                        r_state <= S_DN_RD;
                    end
                end
                S_UP_RD: r_state <= S_UP_CMP;
                S_UP_CMP: begin
                    if (w_up_swap) begin
                        if (w_par == '0) r_top <= r_rd_data;
                        r_idx   <= w_par;
                        r_state <= S_UP_RD;
                    end else begin
                        if (r_idx == '0) r_top <= r_val;
                        r_state <= S_IDLE;
                    end
                end
                S_DN_RD: begin
                    // first pass: read data is the old last entry
                    if (r_idx == '0 && r_val != r_rd_data) r_val <= r_rd_data;
                    r_state <= S_DN_L;
                end
                S_DN_L: begin
                    r_left  <= r_rd_data;
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (w_take_l) begin
                        if (r_idx == '0) r_top <= r_left;
                        r_idx   <= AW'(w_l);
                        r_state <= S_DN_RD;
                    end else if (w_take_r) begin
                        if (r_idx == '0) r_top <= r_rd_data;
                        r_idx   <= AW'(w_r);
                        r_state <= S_DN_RD;
                    end else begin
                        if (r_idx == '0) r_top <= r_val;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.done  = r_done;
    assign o_top        = r_top;
    assign o_pop_value  = r_popv;
    assign o_size       = r_size;
endmodule

@@ hdl/running_median_two_heaps_top.sv @@
// a heap push sifts up one level at a time and a pop sifts down one level at a
// time; a sample is a push, then a pop and a push when rebalancing, then the
// result is loaded into the result register. one request in flight at a time.
// a full store drops the sample and answers with the overflow flag set.
// reset clears sizes and control; heap memories are not cleared.
// ============================================================================
// running_median_two_heaps_top
// running median of unsigned samples using a max-heap and a min-heap
// ============================================================================
module running_median_two_heaps_top #(
    parameter int unsigned CAPACITY     = rmth_pkg::CAPACITY_DEF,
    parameter int unsigned SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [rmth_pkg::SAMPLE_PORT_W-1:0] i_sample,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [rmth_pkg::MEDIAN_PORT_W-1:0] o_median_doubled,
    output logic [rmth_pkg::COUNT_PORT_W-1:0]  o_sample_count,
    output logic        o_overflow
);
    localparam int unsigned DEPTH = CAPACITY / 2 + 1;
    localparam int unsigned SW    = $clog2(DEPTH + 1);
    localparam int unsigned W     = SAMPLE_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE, S_INS, S_POP, S_PUSH, S_RES
    } t_state;

    t_state r_state;
    logic r_pop_lo;   // rebalance direction: pop lower heap
    logic r_drop;     // current request is dropped
    logic r_valid, r_ovf;
    logic [rmth_pkg::MEDIAN_PORT_W-1:0] r_med;
    logic [rmth_pkg::COUNT_PORT_W-1:0]  r_cnt;

    rmth_pkg::t_heap_cmd  w_lo_cmd, w_hi_cmd;
    rmth_pkg::t_heap_stat w_lo_st, w_hi_st;
    logic [W-1:0] w_lo_top, w_hi_top, w_lo_pop, w_hi_pop, w_lo_in, w_hi_in;
    logic [SW-1:0] w_lo_sz, w_hi_sz;
    logic [SW:0] w_total;
    logic w_to_lo;

    assign w_total = {1'b0, w_lo_sz} + {1'b0, w_hi_sz};
    assign w_to_lo = (w_lo_sz == '0) || (W'(i_sample) < w_lo_top);

    rmth_heap #(.DEPTH(DEPTH), .W(W), .IS_MAX(1'b1)) u_lo (
        .i_clk, .i_rst_n, .i_cmd(w_lo_cmd), .i_value(w_lo_in), .o_stat(w_lo_st),
        .o_top(w_lo_top), .o_pop_value(w_lo_pop), .o_size(w_lo_sz));
    rmth_heap #(.DEPTH(DEPTH), .W(W), .IS_MAX(1'b0)) u_hi (
        .i_clk, .i_rst_n, .i_cmd(w_hi_cmd), .i_value(w_hi_in), .o_stat(w_hi_st),
        .o_top(w_hi_top), .o_pop_value(w_hi_pop), .o_size(w_hi_sz));

    assign o_ready = (r_state == S_IDLE);
    logic w_acc;
    assign w_acc = i_valid && o_ready;
    logic w_full;
    assign w_full = (w_total >= (SW+1)'(CAPACITY));
    logic w_busy;
    assign w_busy = w_lo_st.busy || w_hi_st.busy || w_lo_st.done || w_hi_st.done;
    // result register is free or being emptied this cycle
    logic w_load;
    assign w_load = (r_state == S_RES) && (!r_valid || i_ready);

    // command decode
    always_comb begin
        w_lo_cmd = '{start: 1'b0, op: rmth_pkg::t_OP_PUSH};
        w_hi_cmd = '{start: 1'b0, op: rmth_pkg::t_OP_PUSH};
        w_lo_in  = W'(i_sample);
        w_hi_in  = W'(i_sample);
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && !w_full) begin
                    w_lo_cmd.start = w_to_lo;
                    w_hi_cmd.start = !w_to_lo;
                end
            end
            S_INS: begin
                if (!w_busy && w_hi_sz > w_lo_sz + 1'b1) begin
                    w_hi_cmd = '{start: 1'b1, op: rmth_pkg::t_OP_POP};
                end else if (!w_busy && w_lo_sz > w_hi_sz + 1'b1) begin
                    w_lo_cmd = '{start: 1'b1, op: rmth_pkg::t_OP_POP};
                end
            end
            S_POP: begin
                w_lo_in = w_hi_pop;
                w_hi_in = w_lo_pop;
                if (!w_busy) begin
                    w_lo_cmd.start = !r_pop_lo;
                    w_hi_cmd.start = r_pop_lo;
                end
            end
            default: ;
        endcase
    end

    logic [W:0] w_med;
    always_comb begin
        if (w_lo_sz > w_hi_sz)      w_med = {w_lo_top, 1'b0};
        else if (w_hi_sz > w_lo_sz) w_med = {w_hi_top, 1'b0};
        else if (w_lo_sz == '0)     w_med = '0;
        else                        w_med = {1'b0, w_lo_top} + {1'b0, w_hi_top};
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_load || (r_valid && !i_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_drop  <= w_full;
                        r_state <= w_full ? S_RES : S_INS;
                    end
                end
                S_INS: begin
                    if (!w_busy) begin
                        if (w_hi_sz > w_lo_sz + 1'b1) begin
                            r_pop_lo <= 1'b0; r_state <= S_POP;
                        end else if (w_lo_sz > w_hi_sz + 1'b1) begin
                            r_pop_lo <= 1'b1; r_state <= S_POP;
                        end else begin
                            r_state <= S_RES;
                        end
                    end
                end
                S_POP: if (!w_busy) r_state <= S_PUSH;
                S_PUSH: if (!w_busy) r_state <= S_RES;
                S_RES: begin
                    if (w_load) begin
                        r_med   <= rmth_pkg::MEDIAN_PORT_W'(w_med);
                        r_cnt   <= rmth_pkg::COUNT_PORT_W'(w_total);
                        r_ovf   <= r_drop;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_median_doubled = r_med;
    assign o_sample_count   = r_cnt;
    assign o_overflow       = r_ovf;

    // heap sizes never differ by more than one when idle
    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_lo_sz <= w_hi_sz + 1'b1 && w_hi_sz <= w_lo_sz + 1'b1))
        else $error("heaps out of balance");
    // never two heap operations at once
    a_one_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_lo_cmd.start && w_hi_cmd.start)) else $error("both heaps started");
    // store never exceeds capacity
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_total <= (SW+1)'(CAPACITY)) else $error("capacity exceeded");
endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// checks the running median block against a two-heap predictor: samples are
// driven with random gaps, results are checked in order with random stalls,
// and the run fills the store past capacity so that the overflow flag is seen
// ============================================================================

// scoreboard: two-heap median predictor and queue of expected medians
class median_scoreboard;
    localparam int unsigned CAP   = rmth_pkg::CAPACITY_DEF;
    localparam int unsigned DEPTH = CAP / 2 + 2;

    typedef struct {
        logic [32:0] median_doubled;
        logic [10:0] sample_count;
        logic        overflow;
    } t_median_result;

    logic [31:0]    lo_heap [DEPTH];
    logic [31:0]    hi_heap [DEPTH];
    int unsigned    lo_size;
    int unsigned    hi_size;
    t_median_result pending_q [$];
    int unsigned    mismatch_cnt;

    function new();
        lo_size      = 0;
        hi_size      = 0;
        mismatch_cnt = 0;
    endfunction

    // true if a belongs above b in the heap
    function bit above(logic [31:0] a, logic [31:0] b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    function void heap_push(bit is_max, logic [31:0] v);
        int unsigned i;
        int unsigned p;
        logic [31:0] t;
        if (is_max) begin
            i = lo_size; lo_heap[i] = v; lo_size++;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!above(lo_heap[i], lo_heap[p], 1'b1)) break;
                t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
                i = p;
            end
        end else begin
            i = hi_size; hi_heap[i] = v; hi_size++;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!above(hi_heap[i], hi_heap[p], 1'b0)) break;
                t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
                i = p;
            end
        end
    endfunction

    function logic [31:0] heap_pop(bit is_max);
        logic [31:0] h [DEPTH];
        int unsigned n;
        int unsigned i;
        int unsigned l;
        int unsigned best;
        logic [31:0] top;
        logic [31:0] t;
        if (is_max) begin h = lo_heap; n = lo_size; end
        else begin h = hi_heap; n = hi_size; end
        top  = h[0];
        n    = n - 1;
        h[0] = h[n];
        i    = 0;
        forever begin
            l    = 2 * i + 1;
            best = i;
            if (l < n && above(h[l], h[best], is_max)) best = l;
            if (l + 1 < n && above(h[l+1], h[best], is_max)) best = l + 1;
            if (best == i) break;
            t = h[i]; h[i] = h[best]; h[best] = t;
            i = best;
        end
        if (is_max) begin lo_heap = h; lo_size = n; end
        else begin hi_heap = h; hi_size = n; end
        return top;
    endfunction

    // accepted sample: update heaps, queue the expected result
    function void note_sample(logic [31:0] v);
        t_median_result r;
        r.overflow = 1'b0;
        if (lo_size + hi_size >= CAP) begin
            r.overflow = 1'b1;
        end else begin
            if (lo_size == 0 || v < lo_heap[0]) heap_push(1'b1, v);
            else heap_push(1'b0, v);
            if (hi_size > lo_size + 1) heap_push(1'b1, heap_pop(1'b0));
            else if (lo_size > hi_size + 1) heap_push(1'b0, heap_pop(1'b1));
        end
        if (lo_size > hi_size) r.median_doubled = {lo_heap[0], 1'b0};
        else if (hi_size > lo_size) r.median_doubled = {hi_heap[0], 1'b0};
        else r.median_doubled = {1'b0, lo_heap[0]} + {1'b0, hi_heap[0]};
        r.sample_count = 11'(lo_size + hi_size);
        pending_q.push_back(r);
    endfunction

    // accepted result: compare with the oldest expectation
    function void check_result(logic [32:0] md, logic [10:0] cnt, logic ovf);
        t_median_result r;
        if (pending_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("unexpected result: median2=%0d count=%0d ovf=%0b", md, cnt, ovf);
            return;
        end
        r = pending_q.pop_front();
        if (md !== r.median_doubled || cnt !== r.sample_count || ovf !== r.overflow) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("result mismatch: exp median2=%0d count=%0d ovf=%0b, got %0d %0d %0b",
                         r.median_doubled, r.sample_count, r.overflow, md, cnt, ovf);
        end
    endfunction
endclass

module tb;
    localparam int unsigned N_RANDOM    = 1280;
    localparam int unsigned QUIET_TAIL  = 150;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned STALL_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_sample;
    logic        o_valid;
    logic        i_ready;
    logic [32:0] o_median_doubled;
    logic [10:0] o_sample_count;
    logic        o_overflow;

    median_scoreboard median_sb;
    bit          quiet;
    bit          hold_req;
    int unsigned idle_cycles;

    running_median_two_heaps_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample         (i_sample),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_median_doubled (o_median_doubled),
        .o_sample_count   (o_sample_count),
        .o_overflow       (o_overflow)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // result checking at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            median_sb.check_result(o_median_doubled, o_sample_count, o_overflow);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one request, hold until accepted, maybe idle afterwards
    task automatic send_sample(logic [31:0] v);
        @(negedge i_clk);
        i_valid  = 1'b1;
        i_sample = v;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        median_sb.note_sample(v);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_valid  = 1'b0;
            i_sample = $urandom;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
    endtask

    // mix of narrow values for ties, extremes, and full-range values
    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom_range(0, 15);
            2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                                 : 32'(($urandom_range(0, 3)));
            default: return $urandom;
        endcase
    endfunction

    // receiver: random ready bursts and one long hold-off
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_ready  = 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
                if (!quiet) repeat ($urandom_range(0, 30)) @(negedge i_clk);
            end
        end
    end

    initial begin
        logic [31:0] directed [$];
        int unsigned wait_cnt;
        median_sb   = new();
        quiet       = 1'b0;
        hold_req    = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, ties with the lower top, ascending and descending runs
        directed = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5,
                     32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'hFFFF_FFFC, 32'h8000_0000};
        foreach (directed[k]) send_sample(directed[k]);

        // random part: passes capacity so drops are exercised
        for (int unsigned n = 0; n < N_RANDOM; n++) begin
            if (n == 300) hold_req = 1'b1;
            if (n == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
            send_sample(pick_sample());
        end
        @(negedge i_clk);
        i_valid = 1'b0;

        // drain, then let the block settle
        wait_cnt = 0;
        while (median_sb.pending_q.size() != 0 && wait_cnt < STALL_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (100) @(posedge i_clk);
        if (median_sb.mismatch_cnt == 0 && median_sb.pending_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
